// ===== sv/bmrf_pkg.sv =====
// Shared constants, types and the control program of the bit matrix rotate and flip block.
package bmrf_pkg;

   localparam int MAX_DIM   = 16;
   localparam int DIM_CAP   = (MAX_DIM < 16) ? MAX_DIM : 16;
   localparam int DIM_IDX_W = (DIM_CAP > 1) ? $clog2(DIM_CAP) : 1;
   localparam int DIM_CNT_W = $clog2(DIM_CAP + 1);
   localparam int AREA_W    = $clog2(DIM_CAP * DIM_CAP + 1);

   localparam int CFG_W  = 5;
   localparam int IDX_W  = 8;
   localparam int ROW_W  = 16;
   localparam int ROWN_W = 4;
   localparam int CNT_W  = 9;
   localparam int CMP_W  = (AREA_W > IDX_W) ? AREA_W : IDX_W;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_EMIT  = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_DIV,
      OP_CELL,
      OP_ERR,
      OP_ROW
   } uop_type;

   typedef enum logic [1:0] {
      COND_NEVER,
      COND_REM_GE_W,
      COND_MORE_ROWS
   } cond_type;

   localparam int PC_W = 3;
   typedef logic [PC_W-1:0] upc_type;

   localparam upc_type PC_IDLE = 3'd0;
   localparam upc_type PC_DIV  = 3'd1;
   localparam upc_type PC_CELL = 3'd2;
   localparam upc_type PC_ERR  = 3'd3;
   localparam upc_type PC_ROW  = 3'd4;

   typedef struct packed {
      uop_type  op;
      cond_type cond;
      upc_type  target;
      upc_type  next_pc;
   } ucode_type;

   typedef struct packed {
      logic rem_ge_w;
      logic more_rows;
      logic in_range;
   } dp_flags_type;

   function automatic ucode_type ucode_rom(upc_type pc);
      ucode_type word;
      unique case (pc)
         PC_IDLE: word = '{op: OP_NOP, cond: COND_NEVER, target: PC_IDLE, next_pc: PC_IDLE};
         PC_DIV:  word = '{op: OP_DIV, cond: COND_REM_GE_W, target: PC_DIV, next_pc: PC_CELL};
         PC_CELL: word = '{op: OP_CELL, cond: COND_NEVER, target: PC_IDLE, next_pc: PC_IDLE};
         PC_ERR:  word = '{op: OP_ERR, cond: COND_NEVER, target: PC_IDLE, next_pc: PC_IDLE};
         PC_ROW:  word = '{op: OP_ROW, cond: COND_MORE_ROWS, target: PC_ROW, next_pc: PC_IDLE};
         default: word = '{op: OP_NOP, cond: COND_NEVER, target: PC_IDLE, next_pc: PC_IDLE};
      endcase
      return word;
   endfunction

   function automatic logic [DIM_CNT_W-1:0] eff_dim(logic [CFG_W-1:0] r);
      logic [DIM_CNT_W-1:0] d;
      if (r == '0) begin
         d = DIM_CNT_W'(1);
      end else if (int'(r) > DIM_CAP) begin
         d = DIM_CNT_W'(DIM_CAP);
      end else begin
         d = DIM_CNT_W'(r);
      end
      return d;
   endfunction

endpackage

// ===== sv/bmrf_useq.sv =====
// Microprogram sequencer: step counter, control word fetch, dispatch and conditional jumps.
module bmrf_useq
   import bmrf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [1:0]   req_type,
   input  dp_flags_type flags,
   output ucode_type    cw,
   output logic         idle
);

   upc_type pc_ff;
   upc_type pc_in;
   logic    cond_hit;

   always_comb begin
      cw = ucode_rom(pc_ff);
      unique case (cw.cond)
         COND_REM_GE_W:  cond_hit = flags.rem_ge_w;
         COND_MORE_ROWS: cond_hit = flags.more_rows;
         default:        cond_hit = 1'b0;
      endcase
      if (accept) begin
         unique case (req_type) inside
            REQ_WRITE, REQ_READ: pc_in = flags.in_range ? PC_DIV : PC_ERR;
            REQ_EMIT:            pc_in = PC_ROW;
            default:             pc_in = PC_IDLE;
         endcase
      end else begin
         pc_in = cond_hit ? cw.target : cw.next_pc;
      end
   end

   assign idle = (pc_ff == PC_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== sv/bmrf_dp.sv =====
// Datapath: size registers, cell store, set count, index divider, row gather and result registers.
module bmrf_dp
   import bmrf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        req_type,
   input  logic [IDX_W-1:0]  req_cell_index,
   input  logic              req_cell_value,
   input  logic              req_transform,
   input  logic              cfg_write,
   input  logic              cfg_index,
   input  logic [CFG_W-1:0]  cfg_data,
   input  ucode_type         cw,
   output dp_flags_type      flags,
   output logic [AREA_W-1:0] area,
   output logic              rsp_strobe,
   output logic              rsp_status,
   output logic              rsp_read_value,
   output logic [ROW_W-1:0]  rsp_row_bits,
   output logic [ROWN_W-1:0] rsp_row_number,
   output logic [CNT_W-1:0]  rsp_set_count,
   output logic              rsp_last
);

   logic [CFG_W-1:0]     width_ff, width_in, height_ff, height_in;
   logic [DIM_CNT_W-1:0] w_eff, h_eff, rows, shamt;
   logic [IDX_W-1:0]     rem_ff, rem_in;
   logic [DIM_IDX_W-1:0] row_ff, row_in, ctr_ff, ctr_in, col, src_row;
   logic                 value_ff, value_in, write_ff, write_in, xform_ff, xform_in;
   logic [DIM_CAP-1:0]   store_ff [DIM_CAP];
   logic [DIM_CAP-1:0]   store_in [DIM_CAP];
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 old_bit;
   logic [DIM_CAP-1:0]   colvec, revvec, src_word, row_word;

   logic                 strobe_ff, strobe_in, status_ff, status_in, rdval_ff, rdval_in;
   logic [ROW_W-1:0]     bits_ff, bits_in;
   logic [ROWN_W-1:0]    rown_ff, rown_in;
   logic [CNT_W-1:0]     cnt_out_ff, cnt_out_in;
   logic                 last_ff, last_in;

   assign w_eff = eff_dim(width_ff);
   assign h_eff = eff_dim(height_ff);
   assign area  = AREA_W'(w_eff) * AREA_W'(h_eff);

   assign flags.in_range  = CMP_W'(req_cell_index) < CMP_W'(area);
   assign flags.rem_ge_w  = rem_ff >= IDX_W'(w_eff);
   assign rows            = xform_ff ? h_eff : w_eff;
   assign flags.more_rows = (DIM_CNT_W'(ctr_ff) + DIM_CNT_W'(1)) < rows;

   assign col      = rem_ff[DIM_IDX_W-1:0];
   assign old_bit  = store_ff[row_ff][col];
   assign src_row  = DIM_IDX_W'(h_eff - DIM_CNT_W'(1) - DIM_CNT_W'(ctr_ff));
   assign src_word = store_ff[src_row];
   assign shamt    = DIM_CNT_W'(DIM_CAP) - h_eff;

   always_comb begin
      for (int r = 0; r < DIM_CAP; r++) begin
         colvec[r] = store_ff[r][ctr_ff];
      end
      for (int j = 0; j < DIM_CAP; j++) begin
         revvec[j] = colvec[DIM_CAP-1-j];
      end
      row_word = xform_ff ? src_word : (revvec >> shamt);
   end

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      rem_in     = rem_ff;
      row_in     = row_ff;
      ctr_in     = ctr_ff;
      value_in   = value_ff;
      write_in   = write_ff;
      xform_in   = xform_ff;
      store_in   = store_ff;
      count_in   = count_ff;
      strobe_in  = 1'b0;
      status_in  = status_ff;
      rdval_in   = rdval_ff;
      bits_in    = bits_ff;
      rown_in    = rown_ff;
      cnt_out_in = cnt_out_ff;
      last_in    = last_ff;

      if (cfg_write) begin
         if (cfg_index == REG_WIDTH) begin
            width_in = cfg_data;
         end else begin
            height_in = cfg_data;
         end
         for (int r = 0; r < DIM_CAP; r++) begin
            store_in[r] = '0;
         end
         count_in = '0;
      end

      if (accept) begin
         rem_in   = req_cell_index;
         row_in   = '0;
         ctr_in   = '0;
         value_in = req_cell_value;
         write_in = (req_type == REQ_WRITE);
         xform_in = req_transform;
      end

      unique case (cw.op)
         OP_DIV: begin
            if (flags.rem_ge_w) begin
               rem_in = rem_ff - IDX_W'(w_eff);
               row_in = row_ff + DIM_IDX_W'(1);
            end
         end
         OP_CELL: begin
            if (write_ff && (old_bit != value_ff)) begin
               store_in[row_ff][col] = value_ff;
               count_in = value_ff ? count_ff + CNT_W'(1) : count_ff - CNT_W'(1);
            end
            strobe_in  = 1'b1;
            status_in  = 1'b0;
            rdval_in   = write_ff ? 1'b0 : old_bit;
            bits_in    = '0;
            rown_in    = '0;
            cnt_out_in = count_in;
            last_in    = 1'b1;
         end
         OP_ERR: begin
            strobe_in  = 1'b1;
            status_in  = 1'b1;
            rdval_in   = 1'b0;
            bits_in    = '0;
            rown_in    = '0;
            cnt_out_in = count_ff;
            last_in    = 1'b1;
         end
         OP_ROW: begin
            strobe_in  = 1'b1;
            status_in  = 1'b0;
            rdval_in   = 1'b0;
            bits_in    = ROW_W'(row_word);
            rown_in    = ROWN_W'(ctr_ff);
            cnt_out_in = count_ff;
            last_in    = !flags.more_rows;
            if (flags.more_rows) begin
               ctr_in = ctr_ff + DIM_IDX_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(1);
         height_ff <= CFG_W'(1);
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         for (int r = 0; r < DIM_CAP; r++) begin
            store_ff[r] <= '0;
         end
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         store_ff  <= store_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      row_ff     <= row_in;
      ctr_ff     <= ctr_in;
      value_ff   <= value_in;
      write_ff   <= write_in;
      xform_ff   <= xform_in;
      status_ff  <= status_in;
      rdval_ff   <= rdval_in;
      bits_ff    <= bits_in;
      rown_ff    <= rown_in;
      cnt_out_ff <= cnt_out_in;
      last_ff    <= last_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = status_ff;
   assign rsp_read_value = rdval_ff;
   assign rsp_row_bits   = bits_ff;
   assign rsp_row_number = rown_ff;
   assign rsp_set_count  = cnt_out_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== sv/bit_matrix_rotate_flip.sv =====
// Top level of the bit matrix store with clockwise rotate and top-to-bottom flip readout.
// A write or read item runs divide steps and then a cell step, since the cell index is split
// into row and column by a subtract loop of the control program; an out-of-range item runs the
// error step and an emit item runs one row step per output row. Each result appears on the
// rsp_ ports for one cycle with rsp_strobe, in the cycle after its step, and the receiver
// cannot stall it. The next item can be taken in the cycle after the last step of the previous
// one. Writing either size register clears the whole matrix and the set count; busy is high
// while a register write is offered.
module bit_matrix_rotate_flip
   import bmrf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_type,
   input  logic [IDX_W-1:0]  req_cell_index,
   input  logic              req_cell_value,
   input  logic              req_transform,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [CFG_W-1:0]  csr_wdata,
   output logic              rsp_strobe,
   output logic              rsp_status,
   output logic              rsp_read_value,
   output logic [ROW_W-1:0]  rsp_row_bits,
   output logic [ROWN_W-1:0] rsp_row_number,
   output logic [CNT_W-1:0]  rsp_set_count,
   output logic              rsp_last
);

   logic              seq_idle;
   logic              accept;
   logic              cfg_write;
   ucode_type         cw;
   dp_flags_type      flags;
   logic [AREA_W-1:0] area;

   assign busy      = !seq_idle || csr_valid;
   assign csr_ready = seq_idle;
   assign accept    = start && !busy;
   assign cfg_write = csr_valid && csr_ready;

   bmrf_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_type (req_type),
      .flags    (flags),
      .cw       (cw),
      .idle     (seq_idle)
   );

   bmrf_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_type       (req_type),
      .req_cell_index (req_cell_index),
      .req_cell_value (req_cell_value),
      .req_transform  (req_transform),
      .cfg_write      (cfg_write),
      .cfg_index      (csr_index),
      .cfg_data       (csr_wdata),
      .cw             (cw),
      .flags          (flags),
      .area           (area),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_row_bits   (rsp_row_bits),
      .rsp_row_number (rsp_row_number),
      .rsp_set_count  (rsp_set_count),
      .rsp_last       (rsp_last)
   );

   a_strobe_from_step: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(!seq_idle))
      else $error("Result item without a preceding sequencer step.");

   a_last_ends_program: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> seq_idle)
      else $error("Final result item while the sequencer is still running.");

   a_count_within_area: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (int'(rsp_set_count) <= int'(area)))
      else $error("Set count exceeds the number of cells of the matrix.");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the bit matrix store with rotate and flip readout.
module tb
   import bmrf_pkg::*;
();

   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam logic       XF_ROTATE   = 1'b0;
   localparam logic       XF_FLIP     = 1'b1;
   localparam logic       ST_OK       = 1'b0;
   localparam logic       ST_RANGE    = 1'b1;
   localparam int         SETTLE_CYCLES = 24;
   localparam int         STALL_LIMIT   = 2000;

   typedef struct packed {
      logic [1:0]       kind;
      logic [IDX_W-1:0] index;
      logic             value;
      logic             flip;
   } cell_request_type;

   typedef struct packed {
      logic              status;
      logic              bit_read;
      logic [ROW_W-1:0]  row;
      logic [ROWN_W-1:0] row_num;
      logic [CNT_W-1:0]  count;
      logic              last;
   } cell_answer_type;

   logic              clock;
   logic              reset          = 1'b1;
   logic              start          = 1'b0;
   logic              busy;
   logic [1:0]        req_type       = REQ_WRITE;
   logic [IDX_W-1:0]  req_cell_index = '0;
   logic              req_cell_value = 1'b0;
   logic              req_transform  = XF_ROTATE;
   logic              csr_valid      = 1'b0;
   logic              csr_ready;
   logic              csr_index      = REG_WIDTH;
   logic [CFG_W-1:0]  csr_wdata      = '0;
   logic              rsp_strobe;
   logic              rsp_status;
   logic              rsp_read_value;
   logic [ROW_W-1:0]  rsp_row_bits;
   logic [ROWN_W-1:0] rsp_row_number;
   logic [CNT_W-1:0]  rsp_set_count;
   logic              rsp_last;

   cell_request_type pending_requests[$];
   cell_answer_type  answers_due[$];
   cell_request_type offered;
   bit            holding     = 1'b0;
   bit            gaps_on     = 1'b1;
   int            gap_left    = 0;
   int            quiet_cycles = 0;
   int            mismatches  = 0;

   logic [255:0]     shape_cells = '0;
   logic [CNT_W-1:0] cells_set   = '0;
   logic [CFG_W-1:0] width_reg   = CFG_W'(1);
   logic [CFG_W-1:0] height_reg  = CFG_W'(1);

   bit_matrix_rotate_flip u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_cell_index (req_cell_index),
      .req_cell_value (req_cell_value),
      .req_transform  (req_transform),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_row_bits   (rsp_row_bits),
      .rsp_row_number (rsp_row_number),
      .rsp_set_count  (rsp_set_count),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int clamp_dim(input logic [CFG_W-1:0] raw);
      if (raw == '0) begin
         return 1;
      end
      if (int'(raw) > DIM_CAP) begin
         return DIM_CAP;
      end
      return int'(raw);
   endfunction

   task automatic resize_matrix(input logic which, input logic [CFG_W-1:0] raw);
      if (which == REG_WIDTH) begin
         width_reg = raw;
      end else begin
         height_reg = raw;
      end
      shape_cells = '0;
      cells_set = '0;
   endtask

   task automatic predict_matrix_answers(input cell_request_type rq);
      cell_answer_type ans;
      int w;
      int h;
      int n_rows;
      int n_cols;
      int i;
      int j;
      int src;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      ans = '0;
      ans.last = 1'b1;
      if (rq.kind == REQ_WRITE || rq.kind == REQ_READ) begin
         if (int'(rq.index) >= w * h) begin
            ans.status = ST_RANGE;
         end else if (rq.kind == REQ_WRITE) begin
            if (shape_cells[rq.index] != rq.value) begin
               shape_cells[rq.index] = rq.value;
               if (rq.value) begin
                  cells_set = cells_set + 1'b1;
               end else begin
                  cells_set = cells_set - 1'b1;
               end
            end
         end else begin
            ans.bit_read = shape_cells[rq.index];
         end
         ans.count = cells_set;
         answers_due.push_back(ans);
      end else if (rq.kind == REQ_EMIT) begin
         n_rows = (rq.flip == XF_FLIP) ? h : w;
         n_cols = (rq.flip == XF_FLIP) ? w : h;
         for (i = 0; i < n_rows; i++) begin
            ans = '0;
            ans.status = ST_OK;
            for (j = 0; j < n_cols; j++) begin
               if (rq.flip == XF_FLIP) begin
                  src = (h - 1 - i) * w + j;
               end else begin
                  src = (h - 1 - j) * w + i;
               end
               ans.row[j] = shape_cells[src];
            end
            ans.row_num = ROWN_W'(i);
            ans.count = cells_set;
            ans.last = (i + 1 == n_rows);
            answers_due.push_back(ans);
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [ROW_W-1:0] got,
                              input logic [ROW_W-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         holding = 1'b0;
         gap_left = 0;
      end else if (!start || !busy) begin
         if (start) begin
            predict_matrix_answers(offered);
            holding = 1'b0;
         end
         if (!gaps_on) begin
            gap_left = 0;
         end else if (gap_left == 0 && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 19);
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            offered = pending_requests.pop_front();
            holding = 1'b1;
            start <= 1'b1;
            req_type <= offered.kind;
            req_cell_index <= offered.index;
            req_cell_value <= offered.value;
            req_transform <= offered.flip;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cell_answer_type due;
      if (!reset && rsp_strobe) begin
         if (answers_due.size() == 0) begin
            report_mismatch("result arrived with nothing expected");
         end else begin
            due = answers_due.pop_front();
            check_field("status", ROW_W'(rsp_status), ROW_W'(due.status));
            check_field("read_value", ROW_W'(rsp_read_value), ROW_W'(due.bit_read));
            check_field("row_bits", rsp_row_bits, due.row);
            check_field("row_number", ROW_W'(rsp_row_number), ROW_W'(due.row_num));
            check_field("set_count", ROW_W'(rsp_set_count), ROW_W'(due.count));
            check_field("last", ROW_W'(rsp_last), ROW_W'(due.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic queue_req(input logic [1:0] kind, input int index, input logic value,
                            input logic flip);
      cell_request_type rq;
      rq.kind = kind;
      rq.index = IDX_W'(index);
      rq.value = value;
      rq.flip = flip;
      pending_requests.push_back(rq);
   endtask

   task automatic settle();
      while (pending_requests.size() != 0 || holding || answers_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size_reg(input logic which, input logic [CFG_W-1:0] raw);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_wdata <= raw;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      resize_matrix(which, raw);
   endtask

   task automatic queue_random(input int count);
      int n;
      int area;
      int pick;
      int index;
      logic [1:0] kind;
      area = clamp_dim(width_reg) * clamp_dim(height_reg);
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 7) == 0) begin
            index = $urandom_range(0, 255);
         end else begin
            index = $urandom_range(0, area - 1);
         end
         if (pick < 48) begin
            kind = REQ_WRITE;
         end else if (pick < 76) begin
            kind = REQ_READ;
         end else if (pick < 95) begin
            kind = REQ_EMIT;
            index = $urandom_range(0, 255);
         end else begin
            kind = REQ_UNKNOWN;
            index = $urandom_range(0, 255);
         end
         queue_req(kind, index, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw,
                            input int count, input bit gaps);
      settle();
      if ($urandom_range(0, 1) == 0) begin
         write_size_reg(REG_WIDTH, w_raw);
         write_size_reg(REG_HEIGHT, h_raw);
      end else begin
         write_size_reg(REG_HEIGHT, h_raw);
         write_size_reg(REG_WIDTH, w_raw);
      end
      gaps_on = gaps;
      queue_random(count);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      queue_req(REQ_READ, 0, 1'b0, XF_ROTATE);
      queue_req(REQ_READ, 1, 1'b0, XF_ROTATE);
      queue_req(REQ_WRITE, 0, 1'b1, XF_ROTATE);
      queue_req(REQ_WRITE, 0, 1'b1, XF_FLIP);
      queue_req(REQ_EMIT, 255, 1'b1, XF_ROTATE);
      queue_req(REQ_EMIT, 0, 1'b0, XF_FLIP);
      queue_req(REQ_WRITE, 255, 1'b1, XF_FLIP);
      queue_req(REQ_UNKNOWN, 0, 1'b1, XF_FLIP);
      queue_req(REQ_WRITE, 0, 1'b0, XF_ROTATE);

      settle();
      write_size_reg(REG_WIDTH, CFG_W'(16));
      write_size_reg(REG_HEIGHT, CFG_W'(16));
      queue_req(REQ_WRITE, 0, 1'b1, XF_ROTATE);
      queue_req(REQ_WRITE, 255, 1'b1, XF_ROTATE);
      queue_req(REQ_WRITE, 15, 1'b1, XF_ROTATE);
      queue_req(REQ_WRITE, 240, 1'b1, XF_ROTATE);
      queue_req(REQ_READ, 255, 1'b0, XF_ROTATE);
      queue_req(REQ_EMIT, 0, 1'b0, XF_ROTATE);
      queue_req(REQ_EMIT, 0, 1'b0, XF_FLIP);
      queue_req(REQ_READ, 17, 1'b1, XF_FLIP);

      settle();
      write_size_reg(REG_WIDTH, CFG_W'(31));
      write_size_reg(REG_HEIGHT, CFG_W'(0));
      queue_req(REQ_WRITE, 15, 1'b1, XF_ROTATE);
      queue_req(REQ_READ, 16, 1'b0, XF_ROTATE);
      queue_req(REQ_EMIT, 0, 1'b0, XF_ROTATE);
      queue_req(REQ_EMIT, 0, 1'b0, XF_FLIP);

      run_phase(CFG_W'(3), CFG_W'(5), 31, 1'b1);
      run_phase(CFG_W'(1), CFG_W'(16), 31, 1'b0);
      run_phase(CFG_W'(16), CFG_W'(16), 31, 1'b1);
      run_phase(CFG_W'(0), CFG_W'(0), 31, 1'b1);
      run_phase(CFG_W'(7), CFG_W'(2), 31, 1'b0);
      run_phase(CFG_W'(17), CFG_W'(9), 31, 1'b1);
      run_phase(CFG_W'($urandom_range(0, 31)), CFG_W'($urandom_range(0, 31)), 31, 1'b1);
      run_phase(CFG_W'($urandom_range(0, 31)), CFG_W'($urandom_range(0, 31)), 31, 1'b1);
      run_phase(CFG_W'(12), CFG_W'(16), 31, 1'b0);
      run_phase(CFG_W'(16), CFG_W'(1), 31, 1'b0);

      settle();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
sv/bmrf_pkg.sv
sv/bmrf_useq.sv
sv/bmrf_dp.sv
sv/bit_matrix_rotate_flip.sv
bench/tb.sv
